FILE: rtl/kdv_pkg.sv
// Package for the kick drum voice: sequencer states, multiplier operand type,
// fixed-point constants and the note and polynomial coefficient tables.
// No dependencies.
package kdv_pkg;

    // Sine table size. It must be a power of two because the table index is
    // taken straight from the top bits of the phase.
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
    localparam int SINE_SHIFT   = 32 - SINE_BITS;

    // Note numbering. The octave split works on note + NOTE_BIAS, which keeps
    // the value positive for every note. OCT_BIAS octaves are removed again later.
    localparam int NOTE_OFFSET = 24;
    localparam int OCT_BIAS    = 12;
    localparam int NOTE_BIAS   = 12 * OCT_BIAS - NOTE_OFFSET - 69;

    // ceil(2^16 / 12): exact quotient by twelve for any 8-bit value.
    localparam logic [31:0] RECIP_12 = 32'd5462;

    // Fixed-point constants.
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] SINE_GAIN   = 32'd32767;
    localparam logic [23:0] AMP_HALF    = 24'h80_0000;
    localparam logic [31:0] PITCH_RESET = 32'd115343360;
    localparam int          POLY_TERMS  = 5;

    // Configuration register indexes and reset values.
    localparam int          CFG_INDEX_W       = 4;
    localparam logic [3:0]  CFG_MIDI_CHANNEL  = 4'd0;
    localparam logic [3:0]  CFG_SAMPLE_PERIOD = 4'd1;
    localparam logic [3:0]  CFG_VOLUME        = 4'd2;
    localparam logic [3:0]  CFG_DECAY_FACTOR  = 4'd3;
    localparam logic [4:0]  RST_MIDI_CHANNEL  = 5'd1;
    localparam logic [31:0] RST_SAMPLE_PERIOD = 32'd22906492;
    localparam logic [15:0] RST_VOLUME        = 16'd32768;
    localparam logic [23:0] RST_DECAY_FACTOR  = 24'd16775538;

    // MIDI note-on status nibble.
    localparam logic [3:0] MIDI_NOTE_ON = 4'h9;

    // Sequencer states of one frame tick.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DEC_PITCH,
        ST_APPLY,
        ST_NOTE_SET,
        ST_STEP_MUL,
        ST_STEP_ADD,
        ST_ANGLE_MUL,
        ST_ANGLE_SQR,
        ST_ANGLE_X2,
        ST_POLY_MUL,
        ST_POLY_RECIP,
        ST_POLY_BACK,
        ST_POLY_FIX,
        ST_SINE_MUL,
        ST_SINE_ROUND,
        ST_SINE_CLAMP,
        ST_GAIN_AMP,
        ST_GAIN_HI,
        ST_GAIN_LO,
        ST_GAIN_SUM
    } st_t;

    // Operands of the shared multiplier.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } mul_op_t;

    // 440 * 2^(k/12) Hz in Q10.20.
    function automatic logic [29:0] semitone_q20(input logic [3:0] k);
        logic [29:0] v;
        begin
            unique case (k)
                4'd0:    v = 30'd461373440;
                4'd1:    v = 30'd488808132;
                4'd2:    v = 30'd517874176;
                4'd3:    v = 30'd548668578;
                4'd4:    v = 30'd581294109;
                4'd5:    v = 30'd615859655;
                4'd6:    v = 30'd652480576;
                4'd7:    v = 30'd691279090;
                4'd8:    v = 30'd732384684;
                4'd9:    v = 30'd775934544;
                4'd10:   v = 30'd822074013;
                4'd11:   v = 30'd870957077;
                default: v = 30'd0;
            endcase
            return v;
        end
    endfunction

    // Divisors of the Horner steps of the sine polynomial, innermost first.
    function automatic logic [31:0] poly_coef(input logic [2:0] i);
        logic [31:0] c;
        begin
            unique case (i)
                3'd0:    c = 32'd110;
                3'd1:    c = 32'd72;
                3'd2:    c = 32'd42;
                3'd3:    c = 32'd20;
                3'd4:    c = 32'd6;
                default: c = 32'd1;
            endcase
            return c;
        end
    endfunction

    // floor(2^32 / divisor); the quotient it gives is low by at most one.
    function automatic logic [31:0] poly_recip(input logic [2:0] i);
        logic [31:0] m;
        begin
            unique case (i)
                3'd0:    m = 32'd39045157;
                3'd1:    m = 32'd59652323;
                3'd2:    m = 32'd102261126;
                3'd3:    m = 32'd214748364;
                3'd4:    m = 32'd715827882;
                default: m = 32'hFFFF_FFFF;
            endcase
            return m;
        end
    endfunction

    // Pitch of a note in Q12.20 Hz. t is the biased note and q = t / 12.
    // The semitone entry is shifted by the octave, rounding half up on the way
    // down and saturating on the way up.
    function automatic logic [31:0] note_pitch(input logic [7:0] t, input logic [4:0] q);
        logic [8:0]  q12;
        logic [3:0]  k;
        logic [4:0]  sh;
        logic [63:0] v;
        begin
            q12 = {1'b0, q, 3'b000} + {2'b00, q, 2'b00};
            k   = 4'({1'b0, t} - q12);
            v   = {34'd0, semitone_q20(k)};
            if (q >= 5'(OCT_BIAS)) begin
                sh = q - 5'(OCT_BIAS);
                v  = v << sh;
            end else begin
                sh = 5'(OCT_BIAS) - q;
                v  = (v + (64'd1 << (sh - 5'd1))) >> sh;
            end
            if (v > 64'h0000_0000_FFFF_FFFF) begin
                return 32'hFFFF_FFFF;
            end
            return v[31:0];
        end
    endfunction

endpackage

FILE: rtl/kdv_mul_unit.sv
// Shared 32 x 32 multiplier of the kick drum voice with a registered product.
// Depends on kdv_pkg for the operand type.
module kdv_mul_unit
    import kdv_pkg::*;
(
    input  logic        clk,
    input  mul_op_t     op,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    // One product per cycle; the product is read in the following state.
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(op.a) * 64'(op.b);
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/kick_drum_voice_top.sv
// Top level of the kick drum voice: MIDI and tick input channel, sample output
// channel, configuration port and the sequencer. Uses kdv_pkg and kdv_mul_unit.
//
// One kick drum voice. Input items are MIDI events (req_type 0) or frame ticks
// (req_type 1). A note-on on the configured channel arms a new hit; the last
// one before a tick wins, and velocity zero still triggers. Each tick yields
// one signed Q1.15 sample: amplitude and pitch decay, an armed note restarts
// the hit, the phase advances and the sine value is scaled by volume and
// amplitude with saturation. A MIDI event gives no result. A tick keeps the
// input not ready until its sample is in the output register, since every
// product goes through the one shared 32 x 32 multiplier with a
// registered output: two decays, the phase step and its addition, the angle,
// its square and its capture, four passes for each of the five Horner steps
// of the sine polynomial (product, reciprocal multiply for the constant
// division, back multiply, correction), three for the sine product, rounding
// and clamp, and four for the gain. A finished sample waits in the
// output register while MIDI events continue to be taken; a second tick stalls
// in its last cycle until that sample is taken. Configuration writes are
// accepted every cycle and are meant for idle periods.
module kick_drum_voice_top
    import kdv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   req_type,
    input  logic [7:0]             midi_status,
    input  logic [6:0]             midi_note,
    // Output channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [15:0]     sample_out,
    // Configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    // Control and voice state
    st_t         state_reg, state_next;
    logic [4:0]  midi_channel_reg;
    logic [31:0] sample_period_reg;
    logic [15:0] volume_reg;
    logic [23:0] decay_reg;
    logic [23:0] amp_reg, amp_next;
    logic [31:0] pitch_reg, pitch_next;
    logic [32:0] phase_reg, phase_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [6:0]  pend_note_reg, pend_note_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;

    // Working registers of one tick
    logic [30:0] x_reg, x_next;
    logic [31:0] x2_reg, x2_next;
    logic [30:0] v_reg, v_next;
    logic [31:0] n_reg, n_next;
    logic [29:0] q_reg, q_next;
    logic [14:0] sabs_reg, sabs_next;
    logic [6:0]  plo_reg, plo_next;
    logic [47:0] hi_reg, hi_next;
    logic [15:0] sample_reg, sample_next;

    // Shared multiplier
    mul_op_t     mul_op;
    logic [63:0] prod;

    // Combinational helpers
    logic        in_xfer;
    logic        note_on_match;
    logic [7:0]  note_t;
    logic [29:0] r_low;
    logic [30:0] r_angle;
    logic [36:0] phase_sum;
    logic [31:0] rem;
    logic [29:0] q_fix;
    logic [47:0] sine_rnd;
    logic [17:0] sine_mag;
    logic [55:0] gain_total;
    logic [16:0] mag;
    logic [16:0] mag_sat;
    logic        neg;

    kdv_mul_unit u_mul (
        .clk  (clk),
        .op   (mul_op),
        .prod (prod)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_reg;

    // Event filter: note-on on the configured channel.
    assign note_on_match = (midi_status[7:4] == MIDI_NOTE_ON)
                        && ((5'(midi_status[3:0]) + 5'd1) == midi_channel_reg);

    // Biased note for the octave split.
    assign note_t = 8'({1'b0, pend_note_reg} + 8'(NOTE_BIAS));

    // Angle within the quadrant, mirrored in odd quadrants.
    assign r_low   = {phase_reg[29:SINE_SHIFT], SINE_SHIFT'(0)};
    assign r_angle = phase_reg[30] ? (Q30_ONE - {1'b0, r_low}) : {1'b0, r_low};

    // Phase advance with wrap to zero past one.
    assign phase_sum = {4'd0, phase_reg} + {1'b0, prod[63:28]};

    // Correction of the reciprocal quotient.
    assign rem   = n_reg - prod[31:0];
    assign q_fix = (rem >= poly_coef(cnt_reg)) ? (q_reg + 30'd1) : q_reg;

    // Rounding of the sine to Q1.15.
    assign sine_rnd = {1'b0, prod[46:0]} + (48'd1 << 29);
    assign sine_mag = sine_rnd[47:30];

    // Output gain: volume times the high and low parts of amplitude * |sine|.
    assign gain_total = {1'b0, hi_reg, 7'd0} + 56'(prod[22:0]);
    assign mag        = gain_total[55:39];
    assign neg        = phase_reg[31] && (sabs_reg != 15'd0);
    assign mag_sat    = neg ? ((mag > 17'd32768) ? 17'd32768 : mag)
                            : ((mag > 17'd32767) ? 17'd32767 : mag);

    // Sequencer: next state, multiplier operands and working registers.
    always_comb
    begin
        state_next      = state_reg;
        amp_next        = amp_reg;
        pitch_next      = pitch_reg;
        phase_next      = phase_reg;
        pend_valid_next = pend_valid_reg;
        pend_note_next  = pend_note_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        x_next          = x_reg;
        x2_next         = x2_reg;
        v_next          = v_reg;
        n_next          = n_reg;
        q_next          = q_reg;
        sabs_next       = sabs_reg;
        plo_next        = plo_reg;
        hi_next         = hi_reg;
        sample_next     = sample_reg;
        mul_op.a        = 32'(amp_reg);
        mul_op.b        = 32'(decay_reg);

        // A taken sample leaves the output register.
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // Amplitude decay is issued here so that a tick starts at once.
                if (in_xfer) begin
                    if (req_type) begin
                        state_next = ST_DEC_PITCH;
                    end else if (note_on_match) begin
                        pend_valid_next = 1'b1;
                        pend_note_next  = midi_note;
                    end
                end
            end
            ST_DEC_PITCH:
            begin
                amp_next   = prod[47:24];
                mul_op.a   = pitch_reg;
                mul_op.b   = 32'(decay_reg);
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                pitch_next = prod[55:24];
                mul_op.a   = 32'(note_t);
                mul_op.b   = RECIP_12;
                if (pend_valid_reg) begin
                    amp_next   = AMP_HALF;
                    state_next = ST_NOTE_SET;
                end else begin
                    state_next = ST_STEP_MUL;
                end
            end
            ST_NOTE_SET:
            begin
                pitch_next      = note_pitch(note_t, prod[20:16]);
                pend_valid_next = 1'b0;
                state_next      = ST_STEP_MUL;
            end
            ST_STEP_MUL:
            begin
                mul_op.a   = pitch_reg;
                mul_op.b   = sample_period_reg;
                state_next = ST_STEP_ADD;
            end
            ST_STEP_ADD:
            begin
                if (phase_sum > 37'h1_0000_0000) begin
                    phase_next = 33'd0;
                end else begin
                    phase_next = phase_sum[32:0];
                end
                state_next = ST_ANGLE_MUL;
            end
            ST_ANGLE_MUL:
            begin
                mul_op.a   = 32'(r_angle);
                mul_op.b   = HALF_PI_Q30;
                state_next = ST_ANGLE_SQR;
            end
            ST_ANGLE_SQR:
            begin
                x_next     = prod[60:30];
                mul_op.a   = 32'(prod[60:30]);
                mul_op.b   = 32'(prod[60:30]);
                state_next = ST_ANGLE_X2;
            end
            ST_ANGLE_X2:
            begin
                x2_next    = prod[61:30];
                v_next     = Q30_ONE;
                cnt_next   = 3'd0;
                state_next = ST_POLY_MUL;
            end
            ST_POLY_MUL:
            begin
                mul_op.a   = x2_reg;
                mul_op.b   = 32'(v_reg);
                state_next = ST_POLY_RECIP;
            end
            ST_POLY_RECIP:
            begin
                n_next     = prod[61:30];
                mul_op.a   = prod[61:30];
                mul_op.b   = poly_recip(cnt_reg);
                state_next = ST_POLY_BACK;
            end
            ST_POLY_BACK:
            begin
                q_next     = prod[61:32];
                mul_op.a   = 32'(prod[61:32]);
                mul_op.b   = poly_coef(cnt_reg);
                state_next = ST_POLY_FIX;
            end
            ST_POLY_FIX:
            begin
                v_next   = Q30_ONE - {1'b0, q_fix};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'(POLY_TERMS - 1)) begin
                    state_next = ST_SINE_MUL;
                end else begin
                    state_next = ST_POLY_MUL;
                end
            end
            ST_SINE_MUL:
            begin
                mul_op.a   = 32'(x_reg);
                mul_op.b   = 32'(v_reg);
                state_next = ST_SINE_ROUND;
            end
            ST_SINE_ROUND:
            begin
                mul_op.a   = 32'(prod[60:30]);
                mul_op.b   = SINE_GAIN;
                state_next = ST_SINE_CLAMP;
            end
            ST_SINE_CLAMP:
            begin
                sabs_next  = (sine_mag > 18'd32767) ? 15'h7FFF : sine_mag[14:0];
                state_next = ST_GAIN_AMP;
            end
            ST_GAIN_AMP:
            begin
                mul_op.a   = 32'(amp_reg);
                mul_op.b   = 32'(sabs_reg);
                state_next = ST_GAIN_HI;
            end
            ST_GAIN_HI:
            begin
                plo_next   = prod[6:0];
                mul_op.a   = 32'(volume_reg);
                mul_op.b   = prod[38:7];
                state_next = ST_GAIN_LO;
            end
            ST_GAIN_LO:
            begin
                hi_next    = prod[47:0];
                mul_op.a   = 32'(volume_reg);
                mul_op.b   = 32'(plo_reg);
                state_next = ST_GAIN_SUM;
            end
            ST_GAIN_SUM:
            begin
                // Hold the product until the output register is free.
                mul_op.a = 32'(volume_reg);
                mul_op.b = 32'(plo_reg);
                if (!out_valid_reg || out_ready) begin
                    sample_next    = neg ? 16'(17'd0 - mag_sat) : mag_sat[15:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and voice state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            amp_reg        <= 24'd0;
            pitch_reg      <= PITCH_RESET;
            phase_reg      <= 33'd0;
            pend_valid_reg <= 1'b0;
            pend_note_reg  <= 7'd0;
            cnt_reg        <= 3'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            amp_reg        <= amp_next;
            pitch_reg      <= pitch_next;
            phase_reg      <= phase_next;
            pend_valid_reg <= pend_valid_next;
            pend_note_reg  <= pend_note_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Configuration registers, written on each transfer of the config port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            midi_channel_reg  <= RST_MIDI_CHANNEL;
            sample_period_reg <= RST_SAMPLE_PERIOD;
            volume_reg        <= RST_VOLUME;
            decay_reg         <= RST_DECAY_FACTOR;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MIDI_CHANNEL:  midi_channel_reg  <= cfg_data[4:0];
                CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_data;
                CFG_VOLUME:        volume_reg        <= cfg_data[15:0];
                CFG_DECAY_FACTOR:  decay_reg         <= cfg_data[23:0];
                default:           ;
            endcase
        end
    end

    // Working registers of the tick computation.
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        x2_reg     <= x2_next;
        v_reg      <= v_next;
        n_reg      <= n_next;
        q_reg      <= q_next;
        sabs_reg   <= sabs_next;
        plo_reg    <= plo_next;
        hi_reg     <= hi_next;
        sample_reg <= sample_next;
    end

    // A new sample appears only at the end of the gain stage.
    a_out_from_gain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_GAIN_SUM))
        else $error("output valid rose outside the final gain state");

    // Amplitude is reset to zero, set to one half by a note and only decays from there.
    a_amp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        amp_reg <= AMP_HALF)
        else $error("amplitude above one half");

    // The phase never passes one.
    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= 33'h1_0000_0000)
        else $error("phase above one");

    // The Horner loop stays within its terms and its value within one.
    a_poly_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POLY_MUL) |-> (cnt_reg < 3'(POLY_TERMS)) && (v_reg <= Q30_ONE))
        else $error("polynomial loop out of range");

    // Applying a note consumes the armed note.
    a_note_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NOTE_SET) |=> !pend_valid_reg && (amp_reg == AMP_HALF))
        else $error("armed note not consumed");

endmodule
